// File: rtl/multilevel_queue_scheduler_assert.svh
// assertion macros for the multilevel queue scheduler
`ifndef MULTILEVEL_QUEUE_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_QUEUE_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
// expression must hold whenever out of reset
`define MLQS_ASSERT_HOLDS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
// antecedent in one cycle implies consequent in the next
`define MLQS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MLQS_ASSERT_HOLDS(lbl, expr, msg)
`define MLQS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/mlqs_pkg.sv
// shared types and constants of the multilevel queue scheduler
`timescale 1ns / 1ps

package mlqs_pkg;

	localparam int ID_W     = 8;
	localparam int TIME_W   = 16;
	localparam int CLK_W    = 32;
	localparam int PRIO_W   = 4;
	localparam int STATUS_W = 3;
	localparam int LVL_W    = 2;
	localparam int ENTRY_W  = ID_W + TIME_W;
	localparam int NUM_LEVELS = 3;

	localparam logic [TIME_W-1:0] QUANTUM_RESET = 16'd4;

	// request codes
	localparam logic REQ_ARRIVE = 1'b0;
	localparam logic REQ_SLICE  = 1'b1;

	// result codes
	localparam logic [STATUS_W-1:0] RES_ADMIT    = 3'd0;
	localparam logic [STATUS_W-1:0] RES_BAD_PRIO = 3'd1;
	localparam logic [STATUS_W-1:0] RES_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] RES_RUN      = 3'd3;
	localparam logic [STATUS_W-1:0] RES_NONE     = 3'd4;

	// queue levels
	localparam logic [LVL_W-1:0] LVL_HIGH = 2'd0;
	localparam logic [LVL_W-1:0] LVL_MID  = 2'd1;
	localparam logic [LVL_W-1:0] LVL_LOW  = 2'd2;

	// priority bands
	localparam logic [PRIO_W-1:0] PRIO_HIGH_MIN = 4'd1;
	localparam logic [PRIO_W-1:0] PRIO_HIGH_MAX = 4'd3;
	localparam logic [PRIO_W-1:0] PRIO_MID_MIN  = 4'd4;
	localparam logic [PRIO_W-1:0] PRIO_MID_MAX  = 4'd6;
	localparam logic [PRIO_W-1:0] PRIO_LOW_MIN  = 4'd7;
	localparam logic [PRIO_W-1:0] PRIO_LOW_MAX  = 4'd9;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_ARRIVE = 3'b010,
		ST_SLICE  = 3'b100
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic rd_en;
		logic commit_arrive;
		logic commit_slice;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic all_empty;
	} stat_t;

	// band decode: bit LVL_W is the valid flag
	function automatic logic [LVL_W:0] prio_level(input logic [PRIO_W-1:0] prio);
		logic [LVL_W:0] r;
		case (prio) inside
			[PRIO_HIGH_MIN:PRIO_HIGH_MAX]: r = {1'b1, LVL_HIGH};
			[PRIO_MID_MIN:PRIO_MID_MAX]:   r = {1'b1, LVL_MID};
			[PRIO_LOW_MIN:PRIO_LOW_MAX]:   r = {1'b1, LVL_LOW};
			default:                       r = {1'b0, LVL_HIGH};
		endcase
		return r;
	endfunction

endpackage

// File: rtl/multilevel_queue_scheduler.sv
// top level of the three level round robin queue scheduler
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | in        | in_valid / in_stall    | req_type task_id task_priority burst_time
//          |           |                        | arrival_time
//  out     | out       | out_valid / out_stall  | status served_id served_level time_run
//          |           |                        | time_left clock_now finished
//  cfg     | in        | cfg_valid / cfg_ready  | cfg_data (time quantum)
//
// each item is taken in the idle state, and the queue ram head read for a slice is issued
// there; the arrive or slice state then commits pointers, clock, the requeue write into
// that same ram and the result register, so the ram is read before it is written; the
// input stalls until that commit
// reset clears pointers, counts and clock and restores the quantum; queue rams are not swept
// a result waiting under out_stall holds the next item in its commit cycle
// cfg_ready is always high; writes are expected only while idle
`timescale 1ns / 1ps
`include "multilevel_queue_scheduler_assert.svh"

module multilevel_queue_scheduler #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// item channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            req_type,
	input  logic [mlqs_pkg::ID_W-1:0]       task_id,
	input  logic [mlqs_pkg::PRIO_W-1:0]     task_priority,
	input  logic [mlqs_pkg::TIME_W-1:0]     burst_time,
	input  logic [mlqs_pkg::CLK_W-1:0]      arrival_time,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [mlqs_pkg::STATUS_W-1:0]   status,
	output logic [mlqs_pkg::ID_W-1:0]       served_id,
	output logic [mlqs_pkg::LVL_W-1:0]      served_level,
	output logic [mlqs_pkg::TIME_W-1:0]     time_run,
	output logic [mlqs_pkg::TIME_W-1:0]     time_left,
	output logic [mlqs_pkg::CLK_W-1:0]      clock_now,
	output logic                            finished,
	// quantum write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mlqs_pkg::TIME_W-1:0]     cfg_data
);

	mlqs_pkg::cmd_t  cmd;
	mlqs_pkg::stat_t stat;
	logic            in_beat;
	logic            slice_beat;
	logic            commit_any;

	// quantum register takes a write beat at any time
	assign cfg_ready = 1'b1;

	// handshake views used by the checks below
	assign in_beat    = in_valid && !in_stall;
	assign slice_beat = in_beat && (req_type == mlqs_pkg::REQ_SLICE);
	assign commit_any = cmd.commit_arrive || cmd.commit_slice;

	mlqs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	mlqs_datapath #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.req_type     (req_type),
		.task_id      (task_id),
		.task_priority(task_priority),
		.burst_time   (burst_time),
		.arrival_time (arrival_time),
		.status       (status),
		.served_id    (served_id),
		.served_level (served_level),
		.time_run     (time_run),
		.time_left    (time_left),
		.clock_now    (clock_now),
		.finished     (finished)
	);

	// one item in flight: after a taken beat the input stalls until the item commits
	`MLQS_ASSERT_NEXT(a_busy_after_accept, in_beat, in_stall, "input not stalled after accept")
	// every commit presents a result the next cycle
	`MLQS_ASSERT_NEXT(a_commit_shows_result, commit_any, out_valid, "commit without result")
	// a queue read is only started by a taken slice beat
	`MLQS_ASSERT_HOLDS(a_read_on_accept, !cmd.rd_en || slice_beat, "stray queue read")

endmodule

// File: rtl/mlqs_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module mlqs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/mlqs_datapath.sv
// queue memories, pointers, clock and result register
`timescale 1ns / 1ps

module mlqs_datapath #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mlqs_pkg::cmd_t                  cmd,
	output mlqs_pkg::stat_t                 stat,
	input  logic                            cfg_we,
	input  logic [mlqs_pkg::TIME_W-1:0]     cfg_data,
	input  logic                            req_type,
	input  logic [mlqs_pkg::ID_W-1:0]       task_id,
	input  logic [mlqs_pkg::PRIO_W-1:0]     task_priority,
	input  logic [mlqs_pkg::TIME_W-1:0]     burst_time,
	input  logic [mlqs_pkg::CLK_W-1:0]      arrival_time,
	output logic [mlqs_pkg::STATUS_W-1:0]   status,
	output logic [mlqs_pkg::ID_W-1:0]       served_id,
	output logic [mlqs_pkg::LVL_W-1:0]      served_level,
	output logic [mlqs_pkg::TIME_W-1:0]     time_run,
	output logic [mlqs_pkg::TIME_W-1:0]     time_left,
	output logic [mlqs_pkg::CLK_W-1:0]      clock_now,
	output logic                            finished
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int NL = mlqs_pkg::NUM_LEVELS;
	localparam int TW = mlqs_pkg::TIME_W;
	localparam int KW = mlqs_pkg::CLK_W;

	logic [AW-1:0] head_q  [NL];
	logic [CW-1:0] count_q [NL];
	logic [KW-1:0] clock_q;
	logic [TW-1:0] quantum_q;

	// latched item
	logic [mlqs_pkg::ID_W-1:0]   id_q;
	logic [mlqs_pkg::PRIO_W-1:0] prio_q;
	logic [TW-1:0]               burst_q;
	logic [KW-1:0]               arr_q;
	logic [mlqs_pkg::LVL_W-1:0]  lvl_q;
	logic                        none_q;

	logic [mlqs_pkg::LVL_W-1:0]    sel_lvl;
	logic                          all_empty;
	logic [AW-1:0]                 tail [NL];
	logic [NL-1:0]                 ram_we;
	logic [NL-1:0]                 ram_re;
	logic [mlqs_pkg::ENTRY_W-1:0]  ram_wdata;
	logic [mlqs_pkg::ENTRY_W-1:0]  ram_rdata [NL];

	// arrival path
	logic [KW-1:0]              clock_arr;
	logic [mlqs_pkg::LVL_W:0]   pdec;
	logic [mlqs_pkg::LVL_W-1:0] plvl;
	logic                       pfull;

	// slice path
	logic [mlqs_pkg::ENTRY_W-1:0] entry;
	logic [TW-1:0]                rem;
	logic [TW-1:0]                run;
	logic [TW-1:0]                left;
	logic                         fin;
	logic [KW:0]                  clk_sum;
	logic [KW-1:0]                clock_sl;

	assign all_empty = (count_q[0] == '0) && (count_q[1] == '0) && (count_q[2] == '0);
	assign stat.all_empty = all_empty;

	always_comb begin
		if (count_q[0] != '0) begin
			sel_lvl = mlqs_pkg::LVL_HIGH;
		end else if (count_q[1] != '0) begin
			sel_lvl = mlqs_pkg::LVL_MID;
		end else begin
			sel_lvl = mlqs_pkg::LVL_LOW;
		end
	end

	// tail slot of each queue, head plus count wrapped once
	always_comb begin
		logic [SW-1:0] tsum;
		for (int l = 0; l < NL; l++) begin
			tsum = SW'(head_q[l]) + SW'(count_q[l]);
			if (tsum >= SW'(QUEUE_DEPTH)) begin
				tail[l] = AW'(tsum - SW'(QUEUE_DEPTH));
			end else begin
				tail[l] = AW'(tsum);
			end
		end
	end

	assign clock_arr = (all_empty && (arr_q > clock_q)) ? arr_q : clock_q;
	assign pdec      = mlqs_pkg::prio_level(prio_q);
	assign plvl      = pdec[mlqs_pkg::LVL_W-1:0];
	assign pfull     = (count_q[plvl] == CW'(QUEUE_DEPTH));

	assign entry    = ram_rdata[lvl_q];
	assign rem      = entry[TW-1:0];
	assign run      = (rem < quantum_q) ? rem : quantum_q;
	assign left     = rem - run;
	assign fin      = (left == '0);
	assign clk_sum  = {1'b0, clock_q} + (KW+1)'(run);
	assign clock_sl = clk_sum[KW] ? '1 : clk_sum[KW-1:0];

	always_comb begin
		ram_we    = '0;
		ram_wdata = '0;
		if (cmd.commit_arrive && pdec[mlqs_pkg::LVL_W] && !pfull) begin
			ram_we[plvl] = 1'b1;
			ram_wdata    = {id_q, burst_q};
		end else if (cmd.commit_slice && !none_q && !fin) begin
			ram_we[lvl_q] = 1'b1;
			ram_wdata     = {entry[mlqs_pkg::ENTRY_W-1:TW], left};
		end
	end

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			ram_re[l] = cmd.rd_en && (sel_lvl == mlqs_pkg::LVL_W'(l));
		end
	end

	for (genvar g = 0; g < NL; g++) begin : g_queue
		mlqs_ram #(
			.WIDTH(mlqs_pkg::ENTRY_W),
			.DEPTH(QUEUE_DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (ram_we[g]),
			.waddr(tail[g]),
			.wdata(ram_wdata),
			.re   (ram_re[g]),
			.raddr(head_q[g]),
			.rdata(ram_rdata[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= mlqs_pkg::QUANTUM_RESET;
		end else if (cfg_we) begin
			quantum_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			id_q    <= task_id;
			prio_q  <= task_priority;
			burst_q <= burst_time;
			arr_q   <= arrival_time;
			lvl_q   <= sel_lvl;
			none_q  <= all_empty || (req_type == mlqs_pkg::REQ_ARRIVE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= '0;
			for (int l = 0; l < NL; l++) begin
				head_q[l]  <= '0;
				count_q[l] <= '0;
			end
		end else if (cmd.commit_arrive) begin
			clock_q <= clock_arr;
			if (pdec[mlqs_pkg::LVL_W] && !pfull) begin
				count_q[plvl] <= count_q[plvl] + CW'(1);
			end
		end else if (cmd.commit_slice && !none_q) begin
			clock_q <= clock_sl;
			if (head_q[lvl_q] == AW'(QUEUE_DEPTH - 1)) begin
				head_q[lvl_q] <= '0;
			end else begin
				head_q[lvl_q] <= head_q[lvl_q] + AW'(1);
			end
			// pop plus requeue leaves the count as it is
			if (fin) begin
				count_q[lvl_q] <= count_q[lvl_q] - CW'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit_arrive) begin
			served_id <= id_q;
			time_run  <= '0;
			time_left <= burst_q;
			clock_now <= clock_arr;
			finished  <= 1'b0;
			if (!pdec[mlqs_pkg::LVL_W]) begin
				status       <= mlqs_pkg::RES_BAD_PRIO;
				served_level <= mlqs_pkg::LVL_HIGH;
			end else if (pfull) begin
				status       <= mlqs_pkg::RES_FULL;
				served_level <= plvl;
			end else begin
				status       <= mlqs_pkg::RES_ADMIT;
				served_level <= plvl;
			end
		end else if (cmd.commit_slice) begin
			if (none_q) begin
				status       <= mlqs_pkg::RES_NONE;
				served_id    <= '0;
				served_level <= mlqs_pkg::LVL_HIGH;
				time_run     <= '0;
				time_left    <= '0;
				clock_now    <= clock_q;
				finished     <= 1'b0;
			end else begin
				status       <= mlqs_pkg::RES_RUN;
				served_id    <= entry[mlqs_pkg::ENTRY_W-1:TW];
				served_level <= lvl_q;
				time_run     <= run;
				time_left    <= left;
				clock_now    <= clock_sl;
				finished     <= fin;
			end
		end
	end

endmodule

// File: rtl/mlqs_ctrl.sv
// controller state machine of the multilevel queue scheduler
`timescale 1ns / 1ps

module mlqs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            req_type,
	output logic            out_valid,
	input  logic            out_stall,
	input  mlqs_pkg::stat_t stat,
	output mlqs_pkg::cmd_t  cmd
);

	mlqs_pkg::state_t state_q;
	mlqs_pkg::state_t state_d;
	logic             out_valid_q;
	logic             accept;
	logic             out_free;

	assign in_stall  = (state_q != mlqs_pkg::ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			mlqs_pkg::ST_IDLE: begin
				if (accept) begin
					cmd.latch = 1'b1;
					if (req_type == mlqs_pkg::REQ_SLICE) begin
						cmd.rd_en = !stat.all_empty;
						state_d   = mlqs_pkg::ST_SLICE;
					end else begin
						state_d = mlqs_pkg::ST_ARRIVE;
					end
				end
			end
			mlqs_pkg::ST_ARRIVE: begin
				if (out_free) begin
					cmd.commit_arrive = 1'b1;
					state_d           = mlqs_pkg::ST_IDLE;
				end
			end
			mlqs_pkg::ST_SLICE: begin
				if (out_free) begin
					cmd.commit_slice = 1'b1;
					state_d          = mlqs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mlqs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mlqs_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit_arrive || cmd.commit_slice) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
